### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;

  typedef logic signed [KeyW-1:0] key_t;

  // operation codes carried in the mode field
  typedef enum logic [ModeW-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } cell_op_t;

endpackage

### hw/rtl/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// request channel: operation code and key, valid/ready handshake
// ----------------------------------------------------------------------------
interface spq_req_if;

  logic                          valid;
  logic                          ready;
  logic [spq_pkg::ModeW-1:0]     mode;
  logic signed [spq_pkg::KeyW-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);

endinterface

### hw/rtl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// response channel: popped key, count and status, valid/ready handshake
// ----------------------------------------------------------------------------
interface spq_rsp_if #(
  parameter int unsigned CountW = 5
);

  logic                            valid;
  logic                            ready;
  logic signed [spq_pkg::KeyW-1:0] popped_key;
  logic                            popped_valid;
  logic [CountW-1:0]               entry_count;
  logic [spq_pkg::StatusW-1:0]     status;

  modport source (
    output valid, output popped_key, output popped_valid,
    output entry_count, output status, input ready
  );
  modport sink (
    input valid, input popped_key, input popped_valid,
    input entry_count, input status, output ready
  );

endinterface

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: compare with the new key, shift or load
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_op_t   op_i,
  input  spq_pkg::key_t       new_key_i,
  input  spq_pkg::key_t       prev_key_i,
  input  logic                prev_le_i,
  input  spq_pkg::key_t       next_key_i,
  input  logic                valid_i,
  input  logic                at_count_i,
  output logic                le_o,
  output spq_pkg::key_t       key_o
);

  spq_pkg::key_t key_q, key_d;

  // slot holds an entry not above the new key: insertion point is here or earlier
  assign le_o = valid_i && (key_q <= new_key_i);

  always_comb begin
    key_d = key_q;
    if (op_i.push) begin
      if (prev_le_i) begin
        key_d = prev_key_i;
      end else if (le_o || at_count_i) begin
        key_d = new_key_i;
      end
    end else if (op_i.pop) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

### hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue of signed keys held in a chain of compare/shift cells
// ----------------------------------------------------------------------------
// One request is taken per clock cycle: push, pop of the largest key, or
// clear. The keys live in a row of DEPTH cells kept in descending order, the
// largest in cell 0. On a push every cell compares its key with the new one in
// parallel; cells past the insertion point take their upper neighbor's key and
// the cell at the insertion point loads the new key, so the whole row is
// updated at the same clock edge. A pop returns cell 0 and shifts every key one cell
// up. Among equal keys the most recently pushed one leaves first. A push into
// a full queue is dropped with status 2, a pop on an empty queue returns
// status 1 and changes nothing. Each request gives exactly one response, held
// in an output register in the cycle after the request transfer; the request
// side stays ready while that register is empty or being drained, so a new
// request can transfer while the previous response is still waiting. The rate
// is one request per cycle while the response side is ready.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  spq_req_if.sink       req_i,
  spq_rsp_if.source     rsp_o
);

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  logic req_xfer;
  logic rsp_vld_q;

  // request side is free when the response register is empty or draining
  assign req_i.ready = !rsp_vld_q || rsp_o.ready;
  assign req_xfer    = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // decode
  // ---------------------------------------------------------------------------
  logic [CountW-1:0]   count_q, count_d;
  logic                full, empty;
  spq_pkg::cell_op_t   op;
  spq_pkg::status_e    status;
  logic                pop_ok;

  assign full  = (count_q == CountW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    op      = '0;
    status  = spq_pkg::STATUS_OK;
    pop_ok  = 1'b0;
    count_d = count_q;
    case (spq_pkg::mode_e'(req_i.mode))
      spq_pkg::MODE_PUSH: begin
        if (full) begin
          status = spq_pkg::STATUS_FULL;
        end else begin
          op.push = req_xfer;
          count_d = count_q + CountW'(1);
        end
      end
      spq_pkg::MODE_POP: begin
        if (empty) begin
          status = spq_pkg::STATUS_EMPTY;
        end else begin
          op.pop  = req_xfer;
          pop_ok  = 1'b1;
          count_d = count_q - CountW'(1);
        end
      end
      spq_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // cell chain, cell 0 holds the largest key
  // ---------------------------------------------------------------------------
  spq_pkg::key_t cell_key [DEPTH];
  logic          cell_le  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::key_t prev_key, next_key;
    logic          prev_le;

    if (i == 0) begin : g_first
      assign prev_key = req_i.key;
      assign prev_le  = 1'b0;
    end else begin : g_mid
      assign prev_key = cell_key[i-1];
      assign prev_le  = cell_le[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .new_key_i  (req_i.key),
      .prev_key_i (prev_key),
      .prev_le_i  (prev_le),
      .next_key_i (next_key),
      .valid_i    (CountW'(i) < count_q),
      .at_count_i (CountW'(i) == count_q),
      .le_o       (cell_le[i]),
      .key_o      (cell_key[i])
    );
  end

  // ---------------------------------------------------------------------------
  // count and response register
  // ---------------------------------------------------------------------------
  spq_pkg::key_t       pkey_q;
  logic                pvld_q;
  logic [CountW-1:0]   rcount_q;
  spq_pkg::status_e    status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_xfer) begin
        count_q   <= count_d;
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // response payload, loaded on each request transfer
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      pkey_q   <= pop_ok ? cell_key[0] : '0;
      pvld_q   <= pop_ok;
      rcount_q <= count_d;
      status_q <= status;
    end
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.popped_key   = pkey_q;
  assign rsp_o.popped_valid = pvld_q;
  assign rsp_o.entry_count  = rcount_q;
  assign rsp_o.status       = status_q;

endmodule

### verif/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// self-checking testbench for the sorted priority queue
// ----------------------------------------------------------------------------
// Drives push, pop, clear and the unused operation code through the request
// channel and compares every response with a software copy of the queue. The
// copy keeps its keys in ascending order, so the largest key is always last.
// A short directed run covers the extreme keys, pop on empty, push on full,
// clear and the unused code. A random run follows, in stretches that fill,
// drain or churn the queue. The request side sends in bursts with random
// gaps, and the response side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth  = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned RandomItems = 900;

  // operation code the block does not define; it must be ignored
  localparam logic [spq_pkg::ModeW-1:0] ModeUnused = 2'd3;

  localparam spq_pkg::key_t KeyMax = 32'sh7fff_ffff;
  localparam spq_pkg::key_t KeyMin = 32'sh8000_0000;

  // one response as the block should present it
  typedef struct {
    spq_pkg::key_t      popped_key;
    logic               popped_valid;
    logic [CountW-1:0]  entry_count;
    spq_pkg::status_e   status;
  } pq_result_t;

  // operation mix of one stretch of random requests
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  // stall style of the response side
  typedef enum int {RSP_STREAM, RSP_RANDOM, RSP_PERIODIC, RSP_BURSTY} rsp_style_e;

  // --------------------------------------------------------------------------
  // queue model and response checker
  // --------------------------------------------------------------------------
  class pq_scoreboard;
    spq_pkg::key_t held_keys[$];   // ascending, largest at the back
    pq_result_t    awaited[$];     // responses still to come, oldest first
    int            errors;
    int            n_checked;
    int            n_push;
    int            n_full;
    int            n_pop;
    int            n_empty;
    int            n_clear;
    int            n_unused;
    int            peak_fill;

    function int pending();
      return awaited.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // update the model with one request transfer and queue its response
    function void note_request(input logic [spq_pkg::ModeW-1:0] op,
                               input spq_pkg::key_t k);
      pq_result_t res;
      int unsigned pos;
      res.popped_key   = '0;
      res.popped_valid = 1'b0;
      res.status       = spq_pkg::STATUS_OK;
      case (op)
        spq_pkg::MODE_PUSH: begin
          if (held_keys.size() >= Depth) begin
            res.status = spq_pkg::STATUS_FULL;
            n_full++;
          end else begin
            // new key goes in front of the first strictly greater one,
            // so among equal keys the newest sits nearest the top
            pos = held_keys.size();
            for (int i = 0; i < held_keys.size(); i++) begin
              if (k < held_keys[i]) begin
                pos = i;
                break;
              end
            end
            held_keys.insert(pos, k);
            n_push++;
          end
        end
        spq_pkg::MODE_POP: begin
          if (held_keys.size() == 0) begin
            res.status = spq_pkg::STATUS_EMPTY;
            n_empty++;
          end else begin
            res.popped_key   = held_keys.pop_back();
            res.popped_valid = 1'b1;
            n_pop++;
          end
        end
        spq_pkg::MODE_CLEAR: begin
          held_keys.delete();
          n_clear++;
        end
        default: n_unused++;
      endcase
      res.entry_count = CountW'(held_keys.size());
      if (held_keys.size() > peak_fill) peak_fill = held_keys.size();
      awaited.push_back(res);
    endfunction

    // compare one response transfer with the oldest expectation
    task check_response(input spq_pkg::key_t pk, input logic pv,
                        input logic [CountW-1:0] cnt,
                        input logic [spq_pkg::StatusW-1:0] st);
      pq_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("response with none expected (key %0d status %0d)",
                                  pk, st));
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (pk !== want.popped_key)
        report_mismatch($sformatf("response %0d popped_key %0d, expected %0d",
                                  n_checked, pk, want.popped_key));
      if (pv !== want.popped_valid)
        report_mismatch($sformatf("response %0d popped_valid %b, expected %b",
                                  n_checked, pv, want.popped_valid));
      if (cnt !== want.entry_count)
        report_mismatch($sformatf("response %0d entry_count %0d, expected %0d",
                                  n_checked, cnt, want.entry_count));
      if (st !== want.status)
        report_mismatch($sformatf("response %0d status %0d, expected %s",
                                  n_checked, st, want.status.name()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  spq_req_if                   req_if ();
  spq_rsp_if #(.CountW(CountW)) rsp_if ();

  sorted_priority_queue #(
    .DEPTH (Depth)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  pq_scoreboard pq_board = new();

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  // called at a falling edge; holds the request until it transfers, notes it
  // in the model and returns at the next falling edge with valid still high
  task automatic send_request(input logic [spq_pkg::ModeW-1:0] op,
                              input spq_pkg::key_t k);
    req_if.valid = 1'b1;
    req_if.mode  = op;
    req_if.key   = k;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pq_board.note_request(op, k);
    @(negedge clk_i);
  endtask

  // valid low for a number of cycles, payload scrambled meanwhile
  task automatic idle_cycles(input int n);
    req_if.valid = 1'b0;
    req_if.mode  = spq_pkg::ModeW'($urandom_range(0, 3));
    req_if.key   = $urandom();
    repeat (n) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // response side: stall pattern and checker
  // --------------------------------------------------------------------------
  initial begin : rsp_stall_gen
    rsp_style_e style;
    int span;
    int hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      style = rsp_style_e'($urandom_range(0, 3));
      span  = $urandom_range(40, 160);
      for (int c = 0; c < span; c++) begin
        @(negedge clk_i);
        case (style)
          RSP_STREAM:   rsp_if.ready = 1'b1;
          RSP_RANDOM:   rsp_if.ready = ($urandom_range(0, 9) >= 3);
          RSP_PERIODIC: rsp_if.ready = ((c % 7) >= 3);
          default: begin
            // mostly ready, with the odd long stall
            if (hold > 0) begin
              hold--;
              rsp_if.ready = 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
              hold = $urandom_range(4, 12);
              rsp_if.ready = 1'b0;
            end else begin
              rsp_if.ready = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // every response transfer is checked at the rising edge it happens on
  initial begin : rsp_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready)
        pq_board.check_response(rsp_if.popped_key, rsp_if.popped_valid,
                                rsp_if.entry_count, rsp_if.status);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    spq_pkg::key_t             k;
    logic [spq_pkg::ModeW-1:0] op;
    mix_e                      mix;
    int                        mix_left;
    int                        burst_left;
    int                        push_pct;
    int                        r;

    req_if.valid = 1'b0;
    req_if.mode  = spq_pkg::MODE_PUSH;
    req_if.key   = '0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty-queue corner cases first
    send_request(spq_pkg::MODE_POP, 32'sd77);
    send_request(ModeUnused, KeyMax);
    send_request(spq_pkg::MODE_CLEAR, KeyMin);
    // extreme keys and a pair of equal keys
    send_request(spq_pkg::MODE_PUSH, KeyMax);
    send_request(spq_pkg::MODE_PUSH, KeyMin);
    send_request(spq_pkg::MODE_PUSH, 32'sd0);
    send_request(spq_pkg::MODE_PUSH, -32'sd1);
    send_request(spq_pkg::MODE_PUSH, 32'sd5);
    send_request(spq_pkg::MODE_PUSH, 32'sd5);
    send_request(spq_pkg::MODE_POP, 32'sd0);
    // top the queue up to full, then push once more to get it dropped
    for (int i = 0; i < 11; i++)
      send_request(spq_pkg::MODE_PUSH, (i % 2 == 0) ? spq_pkg::key_t'($urandom())
                                                    : spq_pkg::key_t'(i - 5));
    send_request(spq_pkg::MODE_PUSH, KeyMax);
    send_request(spq_pkg::MODE_POP, 32'sd0);
    send_request(spq_pkg::MODE_CLEAR, 32'sd0);
    send_request(spq_pkg::MODE_POP, 32'sd0);

    // random: stretches biased toward filling, draining or churning
    mix_left   = 0;
    burst_left = $urandom_range(1, 24);
    for (int n = 0; n < RandomItems; n++) begin
      if (mix_left == 0) begin
        mix      = mix_e'($urandom_range(0, 2));
        mix_left = $urandom_range(20, 80);
      end
      mix_left--;
      case (mix)
        MIX_FILL:  push_pct = 74;
        MIX_DRAIN: push_pct = 22;
        default:   push_pct = 48;
      endcase

      r = $urandom_range(0, 99);
      if (r < 2)                 op = spq_pkg::MODE_CLEAR;
      else if (r < 4)            op = ModeUnused;
      else if (r < 4 + push_pct) op = spq_pkg::MODE_PUSH;
      else                       op = spq_pkg::MODE_POP;

      // narrow keys give plenty of ties, wide ones exercise every bit
      r = $urandom_range(0, 9);
      if (r < 5)      k = $urandom();
      else if (r < 8) k = $signed($urandom_range(0, 8)) - 32'sd4;
      else begin
        case ($urandom_range(0, 3))
          0:       k = KeyMax;
          1:       k = KeyMin;
          2:       k = 32'sd0;
          default: k = -32'sd1;
        endcase
      end

      send_request(op, k);

      // bursts of random length, now and then a long one with no gaps
      burst_left--;
      if (burst_left == 0) begin
        idle_cycles($urandom_range(0, 6));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                 : $urandom_range(1, 24);
      end
    end

    // drain: wait for the outstanding responses, then a few spare cycles
    req_if.valid = 1'b0;
    for (int w = 0; w < 2000 && pq_board.pending() != 0; w++) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (pq_board.pending() != 0)
      pq_board.report_mismatch($sformatf("%0d responses never arrived",
                                         pq_board.pending()));

    $display("run: %0d responses checked; %0d pushes, %0d pops, %0d clears, %0d unused",
             pq_board.n_checked, pq_board.n_push, pq_board.n_pop, pq_board.n_clear,
             pq_board.n_unused);
    $display("run: %0d pushes dropped on full, %0d pops on empty, peak fill %0d of %0d",
             pq_board.n_full, pq_board.n_empty, pq_board.peak_fill, Depth);
    if (pq_board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog: the slowest correct run stays far below this
  initial begin : watchdog
    #(200_000);
    $display("timeout with %0d responses outstanding", pq_board.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sorted_priority_queue.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_req_if.sv
hw/rtl/spq_rsp_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
verif/tb_sorted_priority_queue.sv
